/* rtl/dda_pkg.sv */
// Shared types and constants for the DDA line rasterizer.
// Used by dda_ctrl, dda_datapath and dda_line_rasterizer_core; no dependencies.
`default_nettype none

package dda_pkg;

  localparam int unsigned COORD_W       = 16;    // Q12.4 endpoint coordinate
  localparam int unsigned COLOR_W       = 32;
  localparam int unsigned PIX_W         = 12;    // reported pixel coordinate
  localparam int unsigned INDEX_W       = 24;    // framebuffer word index
  localparam int unsigned LEN_W         = 12;    // line length in pixels
  localparam int unsigned LEFT_W        = 13;    // pixels still to emit
  localparam int unsigned FRAME_DIM_W   = 13;
  localparam int unsigned MAX_FRAME_DIM = 4096;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned IN_DATA_W     = 96;
  localparam int unsigned OUT_DATA_W    = 88;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    PIX_DRAWN   = 2'd0,
    PIX_CLIPPED = 2'd1,
    PIX_IDLE    = 2'd2
  } pix_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RUN
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch a new line from the input request
    logic div_step;   // one restoring-divide iteration on both lanes
    logic emit_pix;   // emit current pixel, then advance position
    logic emit_idle;  // emit an idle result
  } dda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_zero;   // incoming line has zero length
    logic last_pix;   // current pixel is the final one
    logic out_free;   // output register can take a result this cycle
  } dda_sts_t;

endpackage

`default_nettype wire

/* rtl/dda_div.sv */
// Restoring divider lane, one quotient bit per step.
// Standalone; instantiated twice by dda_datapath.
`default_nettype none

module dda_div #(
  parameter int unsigned DVD_W = 28,
  parameter int unsigned DSR_W = 12
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o
);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
    quo_d = quo_q;
    rem_d = rem_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/dda_ctrl.sv */
// Line sequencer: idle, divide and run states, input handshake, divide counter.
// Depends on dda_pkg.
`default_nettype none

module dda_ctrl #(
  parameter int unsigned DIV_STEPS = 28
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_op_i,
  output logic                   in_ready_o,
  input  wire dda_pkg::dda_sts_t sts_i,
  output dda_pkg::dda_cmd_t      cmd_o
);

  import dda_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             is_start;

  assign in_ready_o = (state_q != ST_DIVIDE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (op_e'(in_op_i) == OP_START);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o.load      = accept && is_start;
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.emit_pix  = accept && !is_start && (state_q == ST_RUN);
    cmd_o.emit_idle = accept && !is_start && (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE, ST_RUN: begin
        if (cmd_o.load) begin
          // a new line replaces any line in flight
          state_d = sts_i.len_zero ? ST_IDLE : ST_DIVIDE;
          cnt_d   = CNT_W'(DIV_STEPS - 1);
        end else if (cmd_o.emit_pix && sts_i.last_pix) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (cnt_q == '0) begin
          state_d = ST_RUN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/dda_datapath.sv */
// Line setup, two divider lanes, position accumulators, pixel rounding,
// clipping, index multiply, frame registers and output register.
// Depends on dda_pkg and dda_div.
`default_nettype none

module dda_datapath #(
  parameter int unsigned STEP_FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [dda_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [dda_pkg::FRAME_DIM_W-1:0] cfg_data_i,
  input  wire dda_pkg::dda_cmd_t               cmd_i,
  output dda_pkg::dda_sts_t                    sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [dda_pkg::OUT_DATA_W-1:0]       out_data_o,
  output logic [dda_pkg::STATUS_W-1:0]         out_status_o,
  output logic                                 out_last_o
);

  import dda_pkg::*;

  localparam int unsigned F       = STEP_FRAC_BITS;
  localparam int unsigned DVD_W   = LEN_W + F;
  localparam int unsigned Q_W     = F + 1;          // step magnitude <= 2^F
  localparam int unsigned POS_W   = F + 15;
  localparam int unsigned SHIFT   = F - 4;          // Q12.4 to position format
  localparam int unsigned PAD_W   = POS_W - COORD_W - SHIFT;
  localparam int unsigned RND_W   = POS_W + 1 - F;  // rounded magnitude
  localparam int unsigned R_W     = RND_W + 1;      // rounded signed coordinate
  localparam int unsigned PROD_W  = PIX_W + FRAME_DIM_W;

  // ---------------- line setup from the input request ----------------
  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COLOR_W-1:0] in_color;
  logic [COORD_W:0]   diff_x, diff_y, abs_x, abs_y;
  logic [LEN_W-1:0]   mag_dx, mag_dy, len;

  assign sx       = in_data_i[15:0];
  assign sy       = in_data_i[31:16];
  assign ex       = in_data_i[47:32];
  assign ey       = in_data_i[63:48];
  assign in_color = in_data_i[95:64];

  always_comb begin
    diff_x = {ex[COORD_W-1], ex} - {sx[COORD_W-1], sx};
    diff_y = {ey[COORD_W-1], ey} - {sy[COORD_W-1], sy};
    abs_x  = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
    abs_y  = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;
    // drop the four fraction bits: truncation toward zero
    mag_dx = abs_x[COORD_W-1:4];
    mag_dy = abs_y[COORD_W-1:4];
    len    = (mag_dx >= mag_dy) ? mag_dx : mag_dy;
  end

  // ---------------- line state ----------------
  logic [LEN_W-1:0]   len_q;
  logic               neg_x_q, neg_y_q;
  logic [POS_W-1:0]   pos_x_q, pos_y_q;
  logic [LEFT_W-1:0]  left_q;
  logic [COLOR_W-1:0] color_q;
  logic [DVD_W-1:0]   quo_x, quo_y;
  logic [POS_W-1:0]   step_x, step_y;

  dda_div #(.DVD_W(DVD_W), .DSR_W(LEN_W)) u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i ({mag_dx, {F{1'b0}}}),
    .divisor_i  (len_q),
    .quotient_o (quo_x)
  );

  dda_div #(.DVD_W(DVD_W), .DSR_W(LEN_W)) u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i ({mag_dy, {F{1'b0}}}),
    .divisor_i  (len_q),
    .quotient_o (quo_y)
  );

  assign step_x = {{(POS_W-Q_W){1'b0}}, quo_x[Q_W-1:0]};
  assign step_y = {{(POS_W-Q_W){1'b0}}, quo_y[Q_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q   <= len;
      neg_x_q <= diff_x[COORD_W];
      neg_y_q <= diff_y[COORD_W];
      pos_x_q <= {{PAD_W{sx[COORD_W-1]}}, sx, {SHIFT{1'b0}}};
      pos_y_q <= {{PAD_W{sy[COORD_W-1]}}, sy, {SHIFT{1'b0}}};
      left_q  <= {1'b0, len};
      color_q <= in_color;
    end else if (cmd_i.emit_pix) begin
      pos_x_q <= neg_x_q ? (pos_x_q - step_x) : (pos_x_q + step_x);
      pos_y_q <= neg_y_q ? (pos_y_q - step_y) : (pos_y_q + step_y);
      left_q  <= left_q - 1'b1;
    end
  end

  // ---------------- frame registers ----------------
  logic [FRAME_DIM_W-1:0] width_q, height_q, cfg_sat;

  assign cfg_sat = (cfg_data_i > FRAME_DIM_W'(MAX_FRAME_DIM)) ?
                   FRAME_DIM_W'(MAX_FRAME_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_sat;
        REG_FRAME_HEIGHT: height_q <= cfg_sat;
        default: ;
      endcase
    end
  end

  // ---------------- pixel of the current position ----------------
  // round half away from zero
  function automatic logic [R_W-1:0] round_pos(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] a;
    logic [POS_W:0]   s;
    logic [R_W-1:0]   r;
    a = p[POS_W-1] ? (~p + 1'b1) : p;
    s = {1'b0, a} + (POS_W+1)'(1 << (F - 1));
    r = {1'b0, s[POS_W:F]};
    return p[POS_W-1] ? (~r + 1'b1) : r;
  endfunction

  logic [R_W-1:0]     px, py;
  logic               in_frame;
  logic [PROD_W-1:0]  prod;
  logic [INDEX_W-1:0] index;

  always_comb begin
    px       = round_pos(pos_x_q);
    py       = round_pos(pos_y_q);
    in_frame = !px[R_W-1] && (px != '0) && !py[R_W-1] && (py != '0) &&
               (px < R_W'(width_q)) && (py < R_W'(height_q));
    prod     = py[PIX_W-1:0] * width_q;
    index    = prod[INDEX_W-1:0] + INDEX_W'(px[PIX_W-1:0]);
  end

  // ---------------- output register ----------------
  logic               out_valid_q;
  logic [PIX_W-1:0]   o_x_q, o_y_q;
  logic [INDEX_W-1:0] o_idx_q;
  logic [COLOR_W-1:0] o_color_q;
  logic               o_we_q, o_last_q;
  pix_status_e        o_status_q;
  logic               emit;

  assign emit = cmd_i.emit_pix || cmd_i.emit_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pix) begin
      o_x_q      <= px[PIX_W-1:0];
      o_y_q      <= py[PIX_W-1:0];
      o_idx_q    <= in_frame ? index : '0;
      o_color_q  <= color_q;
      o_we_q     <= in_frame;
      o_status_q <= in_frame ? PIX_DRAWN : PIX_CLIPPED;
      o_last_q   <= (left_q <= LEFT_W'(1));
    end else if (cmd_i.emit_idle) begin
      o_x_q      <= '0;
      o_y_q      <= '0;
      o_idx_q    <= '0;
      o_color_q  <= '0;
      o_we_q     <= 1'b0;
      o_status_q <= PIX_IDLE;
      o_last_q   <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = {7'b0, o_we_q, o_color_q, o_idx_q, o_y_q, o_x_q};
  assign out_status_o = o_status_q;
  assign out_last_o   = o_last_q;

  assign sts_o.len_zero = (len == '0);
  assign sts_o.last_pix = (left_q <= LEFT_W'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/dda_line_rasterizer_core.sv */
// DDA line rasterizer, top level: wires the sequencer to the datapath.
// Depends on dda_pkg, dda_ctrl, dda_datapath and dda_div.
//
// Usage:
//   Input stream: tuser is the op (start or tick); tdata carries both Q12.4
//   endpoints and the line color. A start request loads a line and returns no
//   result; each tick returns one pixel result on the output stream.
//   Output stream: tdata carries the pixel fields, tuser the status (drawn,
//   clipped, idle) and tlast marks the final pixel of the line.
//   Config channel: index 0 frame width, 1 frame height; write while idle.
// Timing:
//   A start is followed by a setup phase, the bit-per-cycle restoring divide
//   that forms the x and y increments; tready stays low meanwhile. Ticks
//   then go in one per cycle while the output is not stalled, and each
//   result appears in the output register in the cycle after accept.
//   A stalled receiver holds the output register and tready drops until the
//   result is taken.
// Reset: no line is active, frame size returns to 640 x 480.
`default_nettype none

module dda_line_rasterizer_core #(
  parameter int unsigned STEP_FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // slave side
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // start_x, start_y, end_x, end_y, line_color
  input  wire logic [dda_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // op
  input  wire logic                            s_axis_tuser_i,
  // master side
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // pixel_x, pixel_y, pixel_index, pixel_color, write_enable, zero pad
  output logic [dda_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // status
  output logic [dda_pkg::STATUS_W-1:0]         m_axis_tuser_o,
  output logic                                 m_axis_tlast_o,
  // configuration
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [dda_pkg::FRAME_DIM_W-1:0] cfg_data_i
);

  import dda_pkg::*;

  localparam int unsigned DIV_STEPS = STEP_FRAC_BITS + LEN_W;

  dda_cmd_t cmd;
  dda_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dda_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dda_datapath #(.STEP_FRAC_BITS(STEP_FRAC_BITS)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
